// File: hw/rtl/lsed_pkg.sv
// shared widths, defaults, register map and stage tag type of the line-scan edge detector
package lsed_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int SAMPLE_MAX = 4095;
	localparam int DIFF_THR_W = 12;
	localparam int LINE_THR_W = 16;
	localparam int INDEX_W    = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 8;

	localparam int DEF_SCAN_LENGTH   = 128;
	localparam int DEF_DIFF_WINDOW   = 4;
	localparam int DEF_SMOOTH_WINDOW = 5;

	// register select by word address bit
	localparam logic REG_DIFF_THR = 1'b0;
	localparam logic REG_LINE_THR = 1'b1;

	// sideband that travels with a sample through the filter stages
	typedef struct packed {
		logic               side;
		logic               last;
		logic               take;
		logic [INDEX_W-1:0] pos;
	} tag_t;

endpackage

// File: hw/rtl/lsed_filter.sv
// filter pipeline: windowed first difference, threshold, moving sum, second difference
module lsed_filter #(
	parameter int DIFF_WINDOW   = lsed_pkg::DEF_DIFF_WINDOW,
	parameter int SMOOTH_WINDOW = lsed_pkg::DEF_SMOOTH_WINDOW,
	localparam int Q_W  = $clog2(lsed_pkg::SAMPLE_MAX / DIFF_WINDOW + 1),
	localparam int S_W  = $clog2(SMOOTH_WINDOW * (lsed_pkg::SAMPLE_MAX / DIFF_WINDOW) + 1) + 1,
	localparam int DD_W = S_W + 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                in_valid,
	input  logic [lsed_pkg::SAMPLE_W-1:0]       in_sample,
	input  lsed_pkg::tag_t                      in_tag,
	input  logic [lsed_pkg::DIFF_THR_W-1:0]     core_thr,
	output logic                                out_valid,
	output lsed_pkg::tag_t                      out_tag,
	output logic signed [DD_W-1:0]              out_dd
);

	localparam int SW_   = lsed_pkg::SAMPLE_W;
	localparam int SH    = SW_ + $clog2(DIFF_WINDOW);
	localparam int RECIP = ((1 << SH) + DIFF_WINDOW - 1) / DIFF_WINDOW;
	localparam int REC_W = SW_ + 1;
	localparam int PROD_W = SW_ + REC_W;
	localparam int D_W   = Q_W + 1;
	localparam int PL    = DIFF_WINDOW - 1;

	// stage 1: input register
	logic                 v_s1;
	lsed_pkg::tag_t       tag_s1;
	logic [SW_-1:0]       sample_s1;
	logic [SW_-1:0]       pix_q [PL];

	// stage 2: magnitude of the raw difference
	logic                 v_s2;
	lsed_pkg::tag_t       tag_s2;
	logic [SW_-1:0]       mag_s2;
	logic                 neg_s2;

	// stage 3: reciprocal product
	logic                 v_s3;
	lsed_pkg::tag_t       tag_s3;
	logic [PROD_W-1:0]    prod_s3;
	logic                 neg_s3;

	// stage 4: thresholded first difference
	logic                 v_s4;
	lsed_pkg::tag_t       tag_s4;
	logic signed [D_W-1:0] d_s4;
	logic signed [D_W-1:0] win_q [SMOOTH_WINDOW];
	logic signed [S_W-1:0] sum_q;

	// stage 5: moving sum
	logic                 v_s5;
	lsed_pkg::tag_t       tag_s5;
	logic signed [S_W-1:0] s_s5;
	logic signed [S_W-1:0] sline_q [PL];

	// stage 6: second difference
	logic                 v_s6;
	lsed_pkg::tag_t       tag_s6;
	logic signed [DD_W-1:0] dd_s6;

	logic signed [SW_:0]   diff;
	logic [SW_-1:0]        mag;
	logic [Q_W-1:0]        q;
	logic signed [D_W-1:0] q_s;
	logic signed [D_W-1:0] d_nx;
	logic signed [S_W-1:0] sum_nx;
	logic signed [DD_W-1:0] dd_nx;
	logic                  fire1;
	logic                  fire4;
	logic                  fire5;

	assign fire1 = adv && v_s1 && tag_s1.take;
	assign fire4 = adv && v_s4 && tag_s4.take;
	assign fire5 = adv && v_s5 && tag_s5.take;

	always_comb begin
		diff = $signed({1'b0, sample_s1}) - $signed({1'b0, pix_q[PL-1]});
		mag  = diff[SW_] ? SW_'(-diff) : SW_'(diff);
	end

	// quotient is exact for every 12-bit magnitude with this rounded-up reciprocal
	always_comb begin
		q   = prod_s3[SH +: Q_W];
		q_s = D_W'(q);
		if (lsed_pkg::DIFF_THR_W'(q) < core_thr) begin
			d_nx = '0;
		end else if (neg_s3) begin
			d_nx = -q_s;
		end else begin
			d_nx = q_s;
		end
	end

	assign sum_nx = sum_q + S_W'(d_s4) - S_W'(win_q[SMOOTH_WINDOW-1]);
	assign dd_nx  = DD_W'(s_s5) - DD_W'(sline_q[PL-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1    <= in_tag;
			sample_s1 <= in_sample;
			tag_s2    <= tag_s1;
			mag_s2    <= mag;
			neg_s2    <= diff[SW_];
			tag_s3    <= tag_s2;
			prod_s3   <= PROD_W'(mag_s2) * PROD_W'(RECIP);
			neg_s3    <= neg_s2;
			tag_s4    <= tag_s3;
			d_s4      <= d_nx;
			tag_s5    <= tag_s4;
			s_s5      <= sum_nx;
			tag_s6    <= tag_s5;
			dd_s6     <= dd_nx;
		end
	end

	// delay lines start from zero and only move on samples inside the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PL; i++) begin
				pix_q[i]   <= '0;
				sline_q[i] <= '0;
			end
			for (int i = 0; i < SMOOTH_WINDOW; i++) begin
				win_q[i] <= '0;
			end
			sum_q <= '0;
		end else begin
			if (fire1) begin
				pix_q[0] <= sample_s1;
				for (int i = 1; i < PL; i++) begin
					pix_q[i] <= pix_q[i-1];
				end
			end
			if (fire4) begin
				win_q[0] <= d_s4;
				for (int i = 1; i < SMOOTH_WINDOW; i++) begin
					win_q[i] <= win_q[i-1];
				end
				sum_q <= sum_nx;
			end
			if (fire5) begin
				sline_q[0] <= s_s5;
				for (int i = 1; i < PL; i++) begin
					sline_q[i] <= sline_q[i-1];
				end
			end
		end
	end

	assign out_valid = v_s6;
	assign out_tag   = tag_s6;
	assign out_dd    = dd_s6;

endmodule

// File: hw/rtl/line_scan_edge_detector_top.sv
// top level of the line-scan edge detector: stream ports, registers, mark tracking, result
// a result beat comes from the beat that carries tlast once it has passed the filter and the result register
// throughput: one sample beat per cycle through the six-stage filter and the result register
// the whole pipeline stalls only while a result beat waits on m_tready
// reset: arst_n clears thresholds, delay lines, sums, position, mark state and all valids
// after reset the block takes beats at once; no clearing pass
module line_scan_edge_detector_top #(
	parameter int SCAN_LENGTH   = lsed_pkg::DEF_SCAN_LENGTH,
	parameter int DIFF_WINDOW   = lsed_pkg::DEF_DIFF_WINDOW,
	parameter int SMOOTH_WINDOW = lsed_pkg::DEF_SMOOTH_WINDOW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [lsed_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample, [15:12] zero
	input  logic                              s_tuser,   // [0] side (0 left, 1 right)
	input  logic                              s_tlast,   // final pixel of the scan
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [lsed_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] line_index
	output logic                              m_tuser,   // [0] found
	// register port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lsed_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lsed_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lsed_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int IDX_W   = lsed_pkg::INDEX_W;
	localparam int P_W     = $clog2(SCAN_LENGTH + 1);
	localparam int S_W     = $clog2(SMOOTH_WINDOW * (lsed_pkg::SAMPLE_MAX / DIFF_WINDOW) + 1) + 1;
	localparam int DD_W    = S_W + 1;
	localparam int LIM_MUL = DIFF_WINDOW * SMOOTH_WINDOW;
	localparam int LIM_W   = lsed_pkg::LINE_THR_W + $clog2(LIM_MUL + 1);
	localparam int CMP_W   = (DD_W - 1 > LIM_W) ? DD_W - 1 : LIM_W;
	// marks are only trusted once every delay line holds real samples of this scan
	localparam int MARK_START = 2 * (DIFF_WINDOW - 1) + (SMOOTH_WINDOW - 1);
	// a mark is reported at the center of the smoothing window
	localparam int MARK_OFS   = (DIFF_WINDOW - 1) + (SMOOTH_WINDOW - 1) - SMOOTH_WINDOW / 2;

	// configuration
	logic [lsed_pkg::DIFF_THR_W-1:0] diff_thr_q;
	logic [lsed_pkg::LINE_THR_W-1:0] line_thr_q;
	logic [LIM_W-1:0]                lim_q;
	logic                            cfg_wr;

	// pipeline control
	logic                adv;
	logic                s_fire;
	logic [P_W-1:0]      pos_q;
	logic                take;
	lsed_pkg::tag_t      in_tag;

	// filter output
	logic                   f_valid;
	lsed_pkg::tag_t         f_tag;
	logic signed [DD_W-1:0] f_dd;

	// mark tracking
	logic [IDX_W-1:0]    near_q;
	logic                seen_q;
	logic                mark;
	logic [IDX_W-1:0]    mark_pos;
	logic [IDX_W-1:0]    near_nx;
	logic                seen_nx;
	logic [IDX_W-1:0]    index_nx;

	// result register
	logic                m_tvalid_q;
	logic [IDX_W-1:0]    index_q;
	logic                found_q;

	// register port: word-aligned, bit 2 picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_thr_q <= '0;
			line_thr_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				lsed_pkg::REG_DIFF_THR: diff_thr_q <= pwdata[lsed_pkg::DIFF_THR_W-1:0];
				lsed_pkg::REG_LINE_THR: line_thr_q <= pwdata[lsed_pkg::LINE_THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			lsed_pkg::REG_DIFF_THR: prdata = lsed_pkg::APB_DATA_W'(diff_thr_q);
			lsed_pkg::REG_LINE_THR: prdata = lsed_pkg::APB_DATA_W'(line_thr_q);
			default:                prdata = '0;
		endcase
	end

	// scaled line threshold, refreshed every cycle from the register
	always_ff @(posedge clk) begin
		lim_q <= LIM_W'(line_thr_q) * LIM_W'(LIM_MUL);
	end

	// whole pipeline moves unless a result beat is stuck at the output
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv;
	assign s_fire   = s_tvalid && adv;

	// position saturates at the scan length; later samples only carry tlast
	assign take = pos_q < P_W'(SCAN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (s_fire) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (take) begin
				pos_q <= pos_q + P_W'(1);
			end
		end
	end

	always_comb begin
		in_tag.side = s_tuser;
		in_tag.last = s_tlast;
		in_tag.take = take;
		in_tag.pos  = IDX_W'(pos_q);
	end

	lsed_filter #(
		.DIFF_WINDOW   (DIFF_WINDOW),
		.SMOOTH_WINDOW (SMOOTH_WINDOW)
	) u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.in_valid       (s_tvalid),
		.in_sample      (s_tdata[lsed_pkg::SAMPLE_W-1:0]),
		.in_tag         (in_tag),
		.core_thr       (diff_thr_q),
		.out_valid      (f_valid),
		.out_tag        (f_tag),
		.out_dd         (f_dd)
	);

	// a taken sample past the mark start with its second difference above the scaled threshold; negative values never mark
	always_comb begin
		mark = f_tag.take && (int'(f_tag.pos) >= MARK_START) && !f_dd[DD_W-1]
			&& (CMP_W'(f_dd[DD_W-2:0]) > CMP_W'(lim_q));
		mark_pos = f_tag.pos - IDX_W'(MARK_OFS);
		// right camera keeps the first mark, left keeps the latest
		if (mark && (!f_tag.side || !seen_q)) begin
			near_nx = mark_pos;
		end else begin
			near_nx = near_q;
		end
		seen_nx = seen_q || mark;
		if (f_tag.side) begin
			index_nx = seen_nx ? near_nx + IDX_W'(SCAN_LENGTH) : IDX_W'(2 * SCAN_LENGTH - 1);
		end else begin
			index_nx = seen_nx ? near_nx : '0;
		end
	end

	// mark state, cleared at the end of each scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q     <= '0;
			seen_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= f_valid && f_tag.last;
			if (f_valid) begin
				if (f_tag.last) begin
					near_q <= '0;
					seen_q <= 1'b0;
				end else begin
					near_q <= near_nx;
					seen_q <= seen_nx;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (adv && f_valid && f_tag.last) begin
			index_q <= index_nx;
			found_q <= seen_nx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = index_q;
	assign m_tuser  = found_q;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the line-scan edge detector: registers, directed scans, random scans, backpressure
module tb;

	// widths and codes shared with the block
	localparam int   SAMPLE_W     = lsed_pkg::SAMPLE_W;
	localparam int   SAMPLE_MAX   = lsed_pkg::SAMPLE_MAX;
	localparam int   DIFF_THR_W   = lsed_pkg::DIFF_THR_W;
	localparam int   LINE_THR_W   = lsed_pkg::LINE_THR_W;
	localparam int   INDEX_W      = lsed_pkg::INDEX_W;
	localparam int   APB_DATA_W   = lsed_pkg::APB_DATA_W;
	localparam int   APB_ADDR_W   = lsed_pkg::APB_ADDR_W;
	localparam int   S_TDATA_W    = lsed_pkg::S_TDATA_W;
	localparam int   M_TDATA_W    = lsed_pkg::M_TDATA_W;
	localparam logic REG_DIFF_THR = lsed_pkg::REG_DIFF_THR;
	localparam logic REG_LINE_THR = lsed_pkg::REG_LINE_THR;

	// block geometry, taken from the defaults the top level is built with
	localparam int SCAN_LEN   = lsed_pkg::DEF_SCAN_LENGTH;
	localparam int DIFF_WIN   = lsed_pkg::DEF_DIFF_WINDOW;
	localparam int SMOOTH_WIN = lsed_pkg::DEF_SMOOTH_WINDOW;
	// first position at which the delay lines hold only samples of this scan
	localparam int FIRST_MARK_POS = 2 * (DIFF_WIN - 1) + (SMOOTH_WIN - 1);

	// margin that lets the pipeline empty once every owed report is in
	localparam int DRAIN_CYCLES  = 12;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_SAMPLES = 120;
	localparam int PHASE_REPORTS = 4;
	localparam int HOLD_CYCLES   = 300;

	localparam logic [SAMPLE_W-1:0] PX_MIN = '0;
	localparam logic [SAMPLE_W-1:0] PX_MAX = SAMPLE_W'(SAMPLE_MAX);

	// register byte addresses: word select bit above the two byte bits
	localparam logic [APB_ADDR_W-1:0] ADDR_DIFF_THR = {REG_DIFF_THR, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_LINE_THR = {REG_LINE_THR, 2'b00};

	// one end-of-scan report as it leaves the block
	typedef struct packed {
		logic [INDEX_W-1:0] line_index;
		logic               found;
	} scan_report_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [11:0] sample, [15:12] zero
	logic                  s_tuser  = 1'b0; // [0] side (0 left, 1 right)
	logic                  s_tlast  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;         // [7:0] line_index
	logic                  m_tuser;         // [0] found
	logic                  psel     = 1'b0;
	logic                  penable  = 1'b0;
	logic                  pwrite   = 1'b0;
	logic [APB_ADDR_W-1:0] paddr    = '0;
	logic [APB_DATA_W-1:0] pwdata   = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// shadow copies of the threshold registers
	logic [DIFF_THR_W-1:0] diff_thr_cfg = '0;
	logic [LINE_THR_W-1:0] line_thr_cfg = '0;

	// edge tracker state: pixel, difference and sum delay lines plus the scan mark state
	logic [SAMPLE_W-1:0] pix_hist [DIFF_WIN] = '{default: '0};
	int                  diff_hist [SMOOTH_WIN];
	int                  sum_hist [DIFF_WIN];
	int                  scan_pos  = 0;
	logic [INDEX_W-1:0]  mark_pos  = '0;
	bit                  mark_seen = 1'b0;

	// reports still owed by the block, oldest first
	scan_report_t reports_due [$];

	// traffic knobs: idle and stall chances in percent per cycle, and the hold-off left
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_left      = 0;

	int unsigned samples_sent = 0;
	int unsigned reports_made = 0;
	int unsigned mismatches   = 0;
	int unsigned cycle_count  = 0;

	line_scan_edge_detector_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(string what);
		$display("mismatch @%0t: %s", $time, what);
		mismatches++;
	endtask

	// advance the edge tracker by one taken sample; queue a report when the scan ends
	function automatic void track_sample(logic [SAMPLE_W-1:0] px, logic right, logic tail);
		int           d;
		int           s;
		int           dd;
		int           pos;
		longint       lim;
		scan_report_t rep;
		// samples past the end of the line are dropped, only their tlast counts
		if (scan_pos < SCAN_LEN) begin
			for (int j = DIFF_WIN - 1; j > 0; j--) pix_hist[j] = pix_hist[j - 1];
			pix_hist[0] = px;
			// windowed first difference, truncated toward zero, cored by the threshold
			d = (int'(pix_hist[0]) - int'(pix_hist[DIFF_WIN - 1])) / DIFF_WIN;
			if ((d < 0 ? -d : d) < int'(diff_thr_cfg)) d = 0;
			for (int j = SMOOTH_WIN - 1; j > 0; j--) diff_hist[j] = diff_hist[j - 1];
			diff_hist[0] = d;
			// moving sum, then its windowed difference
			s = 0;
			foreach (diff_hist[j]) s += diff_hist[j];
			for (int j = DIFF_WIN - 1; j > 0; j--) sum_hist[j] = sum_hist[j - 1];
			sum_hist[0] = s;
			dd = sum_hist[0] - sum_hist[DIFF_WIN - 1];
			// marks only once the delay lines are free of the previous scan
			if (scan_pos >= FIRST_MARK_POS) begin
				lim = longint'(line_thr_cfg) * DIFF_WIN * SMOOTH_WIN;
				if (longint'(dd) > lim) begin
					pos = scan_pos - (DIFF_WIN - 1) - (SMOOTH_WIN - 1) + SMOOTH_WIN / 2;
					// right camera keeps its first mark, left keeps the latest
					if (!right || !mark_seen) mark_pos = pos[INDEX_W-1:0];
					mark_seen = 1'b1;
				end
			end
			scan_pos++;
		end
		if (tail) begin
			// side of the tlast beat picks the report form
			if (right) begin
				rep.line_index = mark_seen ? INDEX_W'(int'(mark_pos) + SCAN_LEN)
				                           : INDEX_W'(2 * SCAN_LEN - 1);
			end else begin
				rep.line_index = mark_seen ? mark_pos : '0;
			end
			rep.found = mark_seen;
			reports_due.push_back(rep);
			reports_made++;
			// scan state restarts, delay lines keep their contents
			scan_pos  = 0;
			mark_pos  = '0;
			mark_seen = 1'b0;
		end
	endfunction

	// offer one sample beat after a random gap; returns at the edge that takes it
	task automatic send_sample(logic [SAMPLE_W-1:0] px, logic right, logic tail);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(px);
		s_tuser  <= right;
		s_tlast  <= tail;
		// tready is settled by the falling edge, so the beat goes at the next rising one
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		track_sample(px, right, tail);
		samples_sent++;
	endtask

	// result side: a beat seen at the falling edge is taken at the next rising edge
	always @(negedge clk) begin
		scan_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (reports_due.size() == 0) begin
				flag_mismatch($sformatf("report index %0d found %0d with none pending",
					m_tdata, m_tuser));
			end else begin
				want = reports_due.pop_front();
				if (m_tdata[INDEX_W-1:0] !== want.line_index)
					flag_mismatch($sformatf("line_index %0d, want %0d",
						m_tdata[INDEX_W-1:0], want.line_index));
				if (m_tuser !== want.found)
					flag_mismatch($sformatf("found %0b, want %0b", m_tuser, want.found));
			end
		end
	end

	// result side ready: a long hold-off when asked, else random stalls
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_DIFF_THR) diff_thr_cfg = value[DIFF_THR_W-1:0];
		else line_thr_cfg = value[LINE_THR_W-1:0];
	endtask

	// read one register back and compare it with its shadow
	task automatic reg_check(logic [APB_ADDR_W-1:0] addr);
		logic [APB_DATA_W-1:0] got;
		logic [APB_DATA_W-1:0] want;
		want = (addr == ADDR_DIFF_THR) ? APB_DATA_W'(diff_thr_cfg) : APB_DATA_W'(line_thr_cfg);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		got = prdata;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			flag_mismatch($sformatf("register at %0d reads %0h, want %0h", addr, got, want));
	endtask

	task automatic set_thresholds(logic [DIFF_THR_W-1:0] dthr, logic [LINE_THR_W-1:0] lthr);
		reg_write(ADDR_DIFF_THR, APB_DATA_W'(dthr));
		reg_write(ADDR_LINE_THR, APB_DATA_W'(lthr));
		reg_check(ADDR_DIFF_THR);
		reg_check(ADDR_LINE_THR);
	endtask

	// stop offering, wait for every owed report, then let the pipeline empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one scan of random length and shape: flat levels with steps, light dither or pure noise
	task automatic send_random_scan();
		int unsigned         len;
		int unsigned         shape;
		logic [SAMPLE_W-1:0] level;
		logic [SAMPLE_W-1:0] px;
		logic                right;
		logic                mixed;
		logic                noisy;
		shape = $urandom_range(99);
		// mostly short lines, a few so short that at most the last sample can mark, a few around the full length
		if (shape < 10) len = $urandom_range(11, 1);
		else if (shape < 16) len = $urandom_range(SCAN_LEN + 12, SCAN_LEN - 2);
		else len = $urandom_range(40, 12);
		right = 1'($urandom);
		mixed = ($urandom_range(99) < 15);
		noisy = ($urandom_range(99) < 10);
		level = SAMPLE_W'($urandom);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 12) begin
				case ($urandom_range(3))
					0: level = PX_MIN;
					1: level = PX_MAX;
					default: level = SAMPLE_W'($urandom);
				endcase
			end
			px = noisy ? SAMPLE_W'($urandom) : level ^ SAMPLE_W'($urandom_range(3));
			// camera side flipping inside the scan
			if (mixed) right = 1'($urandom);
			send_sample(px, right, i == len - 1);
		end
	endtask

	// register access: reset values, both extremes, back to zero
	task automatic test_registers();
		reg_check(ADDR_DIFF_THR);
		reg_check(ADDR_LINE_THR);
		set_thresholds(PX_MAX, '1);
		set_thresholds('0, '0);
	endtask

	// hand-built scans with both thresholds at zero
	task automatic test_directed();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		// one-pixel scans: nothing found, left reports 0, right reports the far end
		send_sample(PX_MIN, 1'b0, 1'b1);
		send_sample(PX_MAX, 1'b1, 1'b1);
		// full-swing step up then down, right camera switching to left for the tail
		for (int i = 0; i < 16; i++)
			send_sample((i >= 8 && i < 13) ? PX_MAX : PX_MIN, i < 12, i == 15);
		// short alternating left scan ending before any mark can form
		for (int i = 0; i < 5; i++)
			send_sample(i[0] ? PX_MAX : PX_MIN, 1'b0, i == 4);
		wait_drained();
	endtask

	// random scans under one threshold setting and one traffic pattern
	task automatic test_filter_phase(logic [DIFF_THR_W-1:0] dthr, logic [LINE_THR_W-1:0] lthr,
			int unsigned src_pct, int unsigned sink_pct);
		int unsigned samples0;
		int unsigned reports0;
		set_thresholds(dthr, lthr);
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		samples0 = samples_sent;
		reports0 = reports_made;
		while (samples_sent - samples0 < PHASE_SAMPLES || reports_made - reports0 < PHASE_REPORTS)
			send_random_scan();
		wait_drained();
	endtask

	// result side held off while one-pixel scans keep coming, so the block must stall its input
	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		@(negedge clk);
		hold_left = HOLD_CYCLES;
		@(posedge clk);
		for (int k = 0; k < 24; k++)
			send_sample(SAMPLE_W'($urandom), 1'($urandom), 1'b1);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_registers();
		test_directed();
		// no idling, everything passes the coring and any rise marks
		test_filter_phase('0, '0, 0, 0);
		// moderate thresholds, sender mostly idle
		test_filter_phase(DIFF_THR_W'($urandom_range(300, 1)), LINE_THR_W'($urandom_range(80, 1)),
			70, 0);
		// coring at full scale wipes every difference, receiver mostly stalled
		test_filter_phase(PX_MAX, '0, 0, 70);
		// line threshold at full scale, light idling on both sides
		test_filter_phase('0, '1, 7, 7);
		// random settings again with and without idling
		test_filter_phase(DIFF_THR_W'($urandom_range(120)), LINE_THR_W'($urandom_range(40)),
			70, 70);
		test_filter_phase(DIFF_THR_W'($urandom_range(600)), LINE_THR_W'($urandom_range(200)),
			0, 0);
		test_backpressure();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: line_scan_edge_detector_top.f
hw/rtl/lsed_pkg.sv
hw/rtl/lsed_filter.sv
hw/rtl/line_scan_edge_detector_top.sv
verif/tb.sv
